### rtl/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Shared widths, codes, reset values and types of the sync-tip clamp.
// ----------------------------------------------------------------------------
package scp_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int TIP_BITS    = 32;
   localparam int COEF_BITS   = 16;
   localparam int LEVEL_BITS  = 16;
   localparam int CSR_ADDR_BITS = 2;

   localparam int STEP_BITS  = COEF_BITS + TIP_BITS;
   localparam int DIFF_BITS  = TIP_BITS + 1;
   localparam int GPROD_BITS = COEF_BITS + 1 + DIFF_BITS;
   localparam int TERM_BITS  = GPROD_BITS - 24;
   localparam int OUT_BITS   = TERM_BITS + 1;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_RELEASE_RATE     = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_OUTPUT_GAIN      = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TIP_OUTPUT_LEVEL = 2'd2;

   localparam logic [COEF_BITS-1:0]  RELEASE_RATE_RESET     = 16'd16;
   localparam logic [COEF_BITS-1:0]  OUTPUT_GAIN_RESET      = 16'd256;
   localparam logic [LEVEL_BITS-1:0] TIP_OUTPUT_LEVEL_RESET = 16'd16384;

   typedef struct packed {
      logic signed [TIP_BITS-1:0] level;
      logic                       skip;
   } item_type;

   typedef struct packed {
      logic [COEF_BITS-1:0]         release_rate;
      logic [COEF_BITS-1:0]         output_gain;
      logic signed [LEVEL_BITS-1:0] tip_output_level;
   } cfg_type;

   typedef enum logic [2:0] {
      BK_LOAD,
      BK_STEP,
      BK_UPDATE,
      BK_GAIN,
      BK_SEND
   } back_state_type;

   typedef enum logic [1:0] {
      KIND_HOLD,
      KIND_TAKE,
      KIND_RELEASE
   } kind_type;

endpackage

### rtl/scp_front.sv
// ----------------------------------------------------------------------------
// scp_front
// Accepts sample requests, widens them to the tip format and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module scp_front
   import scp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [SAMPLE_BITS-1:0] req_tdata,
   input  logic                   req_tuser,
   output logic                   q_valid,
   output item_type               q_item,
   input  logic                   q_pop
);

   item_type   entry_ff [2];
   item_type   entry_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign pop        = q_pop && q_valid;
   assign q_item     = entry_ff[rd_ptr_ff];

   always_comb begin
      entry_in.level = {req_tdata, {(TIP_BITS-SAMPLE_BITS){1'b0}}};
      entry_in.skip  = req_tuser;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

### rtl/scp_back.sv
// ----------------------------------------------------------------------------
// scp_back
// Updates the tracked sync tip and forms the restored envelope level for one
// queued sample at a time, holding the result in an output register.
// ----------------------------------------------------------------------------
module scp_back
   import scp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  q_valid,
   input  item_type              q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [LEVEL_BITS-1:0] rsp_tdata
);

   back_state_type state_ff, state_in;
   kind_type       kind_ff, kind_in;

   logic signed [TIP_BITS-1:0]   tip_ff, tip_in;
   logic                         seeded_ff, seeded_in;
   logic signed [TIP_BITS-1:0]   x_ff, x_in;
   logic [TIP_BITS-1:0]          dist_ff, dist_in;
   logic [STEP_BITS-1:0]         step_ff, step_in;
   logic signed [GPROD_BITS-1:0] gprod_ff, gprod_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0]        rsp_data_ff, rsp_data_in;

   logic signed [DIFF_BITS-1:0]  head_diff;
   logic signed [DIFF_BITS-1:0]  out_diff;
   logic [STEP_BITS:0]           step_round;
   logic [TIP_BITS-1:0]          inc;
   logic signed [GPROD_BITS-1:0] gprod_round;
   logic signed [TERM_BITS-1:0]  term;
   logic signed [OUT_BITS-1:0]   level_full;
   logic                         out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      tip_in       = tip_ff;
      seeded_in    = seeded_ff;
      x_in         = x_ff;
      dist_in      = dist_ff;
      step_in      = step_ff;
      gprod_in     = gprod_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      q_pop        = 1'b0;
      out_free     = !rsp_valid_ff || rsp_tready;

      head_diff   = DIFF_BITS'(q_item.level) - DIFF_BITS'(tip_ff);
      out_diff    = DIFF_BITS'(x_ff) - DIFF_BITS'(tip_ff);
      step_round  = {1'b0, step_ff} + (STEP_BITS+1)'(32768);
      inc         = step_round[STEP_BITS-1:16];
      gprod_round = gprod_ff + GPROD_BITS'(25'sd8388608);
      term        = TERM_BITS'(gprod_round >>> 24);
      level_full  = OUT_BITS'(cfg.tip_output_level) - OUT_BITS'(term);

      unique case (state_ff)
         BK_LOAD: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               x_in    = q_item.level;
               dist_in = head_diff[TIP_BITS-1:0];
               if (q_item.skip) begin
                  kind_in = KIND_HOLD;
               end else if (!seeded_ff || head_diff < 0) begin
                  kind_in = KIND_TAKE;
               end else begin
                  kind_in = KIND_RELEASE;
               end
               state_in = BK_STEP;
            end
         end
         BK_STEP: begin
            step_in  = STEP_BITS'(cfg.release_rate) * STEP_BITS'(dist_ff);
            state_in = BK_UPDATE;
         end
         BK_UPDATE: begin
            case (kind_ff)
               KIND_TAKE: begin
                  tip_in    = x_ff;
                  seeded_in = 1'b1;
               end
               KIND_RELEASE: begin
                  tip_in    = tip_ff + $signed(inc);
                  seeded_in = 1'b1;
               end
               default: begin
                  tip_in = tip_ff;
               end
            endcase
            state_in = BK_GAIN;
         end
         BK_GAIN: begin
            gprod_in = GPROD_BITS'($signed({1'b0, cfg.output_gain})) * GPROD_BITS'(out_diff);
            state_in = BK_SEND;
         end
         BK_SEND: begin
            if (out_free) begin
               if (level_full > OUT_BITS'(32767)) begin
                  rsp_data_in = 16'h7FFF;
               end else if (level_full < -OUT_BITS'(32768)) begin
                  rsp_data_in = 16'h8000;
               end else begin
                  rsp_data_in = level_full[LEVEL_BITS-1:0];
               end
               rsp_valid_in = 1'b1;
               state_in     = BK_LOAD;
            end
         end
         default: begin
            state_in = BK_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_LOAD;
         tip_ff       <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tip_ff       <= tip_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      x_ff        <= x_in;
      dist_ff     <= dist_in;
      step_ff     <= step_in;
      gprod_ff    <= gprod_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### rtl/sync_tip_clamp_restore.sv
// ----------------------------------------------------------------------------
// sync_tip_clamp_restore
// Sync-tip clamp and DC restoration of a composite video sample stream.
//
//   Channel  Direction  Payload
//   req      in         tdata: sample[15:0]; tuser: not_finite
//   rsp      out        tdata: envelope_level[15:0]
//   csr      in         addr 0 release_rate, 1 output_gain, 2 tip_output_level
//
// Each request steps through the back-end states load, step, update, gain and
// send in turn. The front queue holds two requests, so requests are taken
// while the back end works or a response waits.
// Reset is synchronous; it clears the tip, the seeded flag and the queue.
// A stalled response holds the back end in its final step only.
// ----------------------------------------------------------------------------
module sync_tip_clamp_restore
   import scp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [SAMPLE_BITS-1:0]   req_tdata,   // sample
   input  logic                     req_tuser,   // not_finite
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [LEVEL_BITS-1:0]    rsp_tdata,   // envelope_level
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [COEF_BITS-1:0]     csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   item_type q_item;
   logic     q_valid;
   logic     q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_RELEASE_RATE:     cfg_in.release_rate     = csr_wdata;
            CSR_OUTPUT_GAIN:      cfg_in.output_gain      = csr_wdata;
            CSR_TIP_OUTPUT_LEVEL: cfg_in.tip_output_level = $signed(csr_wdata);
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.release_rate     <= RELEASE_RATE_RESET;
         cfg_ff.output_gain      <= OUTPUT_GAIN_RESET;
         cfg_ff.tip_output_level <= $signed(TIP_OUTPUT_LEVEL_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   scp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   scp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
